FILE: hdl/mck_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse keyer package
// Shared widths, register indexes, descriptor and configuration types, and
// the character classification that turns a symbol into a keying descriptor.
// ----------------------------------------------------------------------------
package mck_pkg;

  localparam int SYM_W       = 8;
  localparam int TICK_W      = 10;
  localparam int CFG_IDX_W   = 3;
  localparam int MAX_ELEM    = 5;
  localparam int CNT_W       = $clog2(MAX_ELEM + 1);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int NUM_LETTERS = 26;
  localparam int NUM_DIGITS  = 10;
  localparam int LIDX_W      = $clog2(NUM_LETTERS);
  localparam int DIDX_W      = $clog2(NUM_DIGITS);

  localparam logic [SYM_W-1:0] SYM_END   = 8'h00;
  localparam logic [SYM_W-1:0] SYM_SPACE = 8'h20;
  localparam logic [SYM_W-1:0] SYM_ZERO  = 8'h30;
  localparam logic [SYM_W-1:0] SYM_NINE  = 8'h39;
  localparam logic [SYM_W-1:0] SYM_A     = 8'h41;
  localparam logic [SYM_W-1:0] SYM_Z     = 8'h5A;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DOT        = 3'd0,
    REG_DASH       = 3'd1,
    REG_ELEM_GAP   = 3'd2,
    REG_LETTER_GAP = 3'd3,
    REG_WORD_GAP   = 3'd4
  } cfg_reg_t;

  localparam logic [TICK_W-1:0] DOT_RESET        = 10'd4;
  localparam logic [TICK_W-1:0] DASH_RESET       = 10'd12;
  localparam logic [TICK_W-1:0] ELEM_GAP_RESET   = 10'd4;
  localparam logic [TICK_W-1:0] LETTER_GAP_RESET = 10'd12;
  localparam logic [TICK_W-1:0] WORD_GAP_RESET   = 10'd16;

  typedef struct packed {
    logic [TICK_W-1:0] dot;
    logic [TICK_W-1:0] dash;
    logic [TICK_W-1:0] elem_gap;
    logic [TICK_W-1:0] letter_gap;
    logic [TICK_W-1:0] word_gap;
  } cfg_t;

  // One queued item: what the back end has to key out for it.
  typedef struct packed {
    logic                is_end;
    logic                is_space;
    logic                bad;
    logic                lead;
    logic [CNT_W-1:0]    count;
    logic [MAX_ELEM-1:0] dashes;  // bit i set: element i is a dash
  } desc_t;

  localparam logic [CNT_W-1:0] LETTER_LEN [NUM_LETTERS] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };

  localparam logic [MAX_ELEM-1:0] LETTER_DASH [NUM_LETTERS] = '{
    5'b00010, 5'b00001, 5'b00101, 5'b00001, 5'b00000, 5'b00100, 5'b00011,
    5'b00000, 5'b00000, 5'b01110, 5'b00101, 5'b00010, 5'b00011, 5'b00001,
    5'b00111, 5'b00110, 5'b01011, 5'b00010, 5'b00000, 5'b00001, 5'b00100,
    5'b01000, 5'b00110, 5'b01001, 5'b01101, 5'b00011
  };

  // Every digit has five elements.
  localparam logic [MAX_ELEM-1:0] DIGIT_DASH [NUM_DIGITS] = '{
    5'b11111, 5'b11110, 5'b11100, 5'b11000, 5'b10000,
    5'b00000, 5'b00001, 5'b00011, 5'b00111, 5'b01111
  };

  function automatic desc_t mck_classify(input logic [SYM_W-1:0] sym,
                                         input logic started);
    desc_t             d;
    logic              is_letter;
    logic              is_digit;
    logic [SYM_W-1:0]  l_off;
    logic [SYM_W-1:0]  d_off;
    is_letter  = (sym >= SYM_A) && (sym <= SYM_Z);
    is_digit   = (sym >= SYM_ZERO) && (sym <= SYM_NINE);
    l_off      = sym - SYM_A;
    d_off      = sym - SYM_ZERO;
    d          = '0;
    d.is_end   = (sym == SYM_END);
    d.is_space = (sym == SYM_SPACE);
    d.bad      = !is_letter && !is_digit && !d.is_end && !d.is_space;
    d.lead     = !started && !d.is_end;
    if (is_letter) begin
      d.count  = LETTER_LEN[l_off[LIDX_W-1:0]];
      d.dashes = LETTER_DASH[l_off[LIDX_W-1:0]];
    end else if (is_digit) begin
      d.count  = CNT_W'(MAX_ELEM);
      d.dashes = DIGIT_DASH[d_off[DIDX_W-1:0]];
    end
    return d;
  endfunction

endpackage

FILE: hdl/mck_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse keyer front end
// Accepts characters, classifies them and tracks whether a message is open,
// so that the first character of a message is marked for a leading word gap.
// ----------------------------------------------------------------------------
module mck_front import mck_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [SYM_W-1:0] symbol,
  output logic             full,
  input  logic             q_full,
  output logic             q_push,
  output desc_t            q_data
);

  logic started;
  logic started_next;

  assign full   = q_full;
  assign q_push = push && !q_full;
  assign q_data = mck_classify(symbol, started);

  always_comb begin
    started_next = started;
    if (q_push) begin
      started_next = (symbol != SYM_END);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
    end else begin
      started <= started_next;
    end
  end

endmodule

FILE: hdl/mck_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse keyer descriptor queue
// A short register queue between the front and back ends.
// ----------------------------------------------------------------------------
module mck_queue import mck_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t data_in,
  output logic  full,
  input  logic  pop,
  output logic  valid,
  output desc_t head
);

  desc_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign head    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/mck_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse keyer back end
// Steps through the queued descriptor one segment per cycle while its output
// register is free or being taken, and holds each segment there until taken.
// ----------------------------------------------------------------------------
module mck_back import mck_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  desc_t             head,
  input  logic              head_valid,
  output logic              head_pop,
  input  logic              pop,
  output logic              empty,
  output logic              light_on,
  output logic [TICK_W-1:0] duration,
  output logic              last,
  output logic              idle,
  output logic              bad_symbol
);

  typedef enum logic [3:0] {
    PH_LEAD = 4'b0001,
    PH_ON   = 4'b0010,
    PH_GAP  = 4'b0100,
    PH_TAIL = 4'b1000
  } phase_t;

  phase_t            phase;
  phase_t            phase_next;
  phase_t            cur;
  phase_t            start_phase;
  phase_t            follow;
  logic              fresh;
  logic              fresh_next;
  logic [CNT_W-1:0]  elem_idx;
  logic [CNT_W-1:0]  elem_idx_next;
  logic [CNT_W-1:0]  elem_inc;
  logic              out_valid;
  logic              emit;
  logic              seg_on;
  logic [TICK_W-1:0] seg_dur;
  logic              seg_last;
  logic              seg_idle;
  logic              seg_bad;

  assign empty    = !out_valid;
  assign emit     = head_valid && (!out_valid || pop);
  assign elem_inc = elem_idx + 1'b1;

  always_comb begin
    if (head.lead) begin
      start_phase = PH_LEAD;
    end else if (head.count != '0) begin
      start_phase = PH_ON;
    end else begin
      start_phase = PH_TAIL;
    end
    cur = fresh ? start_phase : phase;
  end

  always_comb begin
    seg_on        = 1'b0;
    seg_dur       = '0;
    seg_last      = 1'b0;
    seg_idle      = 1'b0;
    seg_bad       = 1'b0;
    follow        = PH_TAIL;
    elem_idx_next = elem_idx;
    head_pop      = 1'b0;
    unique case (cur)
      PH_LEAD: begin
        seg_dur = cfg.word_gap;
        seg_bad = head.bad;
        follow  = (head.count != '0) ? PH_ON : PH_TAIL;
      end
      PH_ON: begin
        seg_on  = 1'b1;
        seg_dur = head.dashes[elem_idx] ? cfg.dash : cfg.dot;
        follow  = PH_GAP;
      end
      PH_GAP: begin
        seg_dur = cfg.elem_gap;
        follow  = (elem_inc == head.count) ? PH_TAIL : PH_ON;
        if (emit) begin
          elem_idx_next = elem_inc;
        end
      end
      PH_TAIL: begin
        seg_last = 1'b1;
        if (head.is_end) begin
          seg_idle = 1'b1;
        end else if (head.is_space) begin
          seg_dur = cfg.word_gap;
        end else begin
          seg_dur = cfg.letter_gap;
          seg_bad = head.bad;
        end
        head_pop = emit;
        if (emit) begin
          elem_idx_next = '0;
        end
      end
      default: begin
        follow = PH_TAIL;
      end
    endcase
  end

  always_comb begin
    phase_next = phase;
    fresh_next = fresh;
    if (emit) begin
      if (cur == PH_TAIL) begin
        fresh_next = 1'b1;
        phase_next = PH_LEAD;
      end else begin
        fresh_next = 1'b0;
        phase_next = follow;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_LEAD;
      fresh     <= 1'b1;
      elem_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      phase    <= phase_next;
      fresh    <= fresh_next;
      elem_idx <= elem_idx_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      light_on   <= seg_on;
      duration   <= seg_dur;
      last       <= seg_last;
      idle       <= seg_idle;
      bad_symbol <= seg_bad;
    end
  end

  // The element index never runs past the elements of the item in hand.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    head_valid && !fresh && (phase == PH_ON || phase == PH_GAP)
      |-> elem_idx < head.count)
    else $error("element index beyond element count");

  // The end-of-message result is an empty, final off segment.
  a_idle_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && idle |-> last && !light_on && duration == '0 && !bad_symbol)
    else $error("malformed idle result");

  // An on segment is never the last of an item and never flagged.
  a_on_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && light_on |-> !last && !bad_symbol && !idle)
    else $error("malformed on segment");

  // The queue entry is released exactly when its final segment is issued.
  a_pop_last: assert property (@(posedge clk) disable iff (rst)
    head_pop |=> out_valid && last)
    else $error("descriptor released without a final segment");

  // Back end restarts at a fresh item after reset.
  a_reset_fresh: assert property (@(posedge clk)
    !rst && $past(rst) |-> fresh && elem_idx == '0 && !out_valid)
    else $error("back end not reset");

endmodule

FILE: hdl/morse_code_keyer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse code keyer
// Turns a stream of characters into timed on and off light segments.
// ----------------------------------------------------------------------------
// Characters enter through push/full; an item is taken on a clock edge with
// push high and full low. Segments leave through empty/pop; the oldest one is
// on the result ports while empty is low and is taken when pop is high.
// A character yields one to twelve segments: a leading word gap on the first
// character of a message, an on segment and an element gap for each dot or
// dash, and a closing letter gap (a word gap for a space). A zero character
// yields one idle segment and ends the message.
// The back end issues one segment per cycle while the output register is free
// or being taken; a four-entry queue lets characters arrive while earlier
// ones are still being keyed. A taken character is written into the queue,
// and its first segment is then registered into the output register.
// When the receiver stalls, the output register holds and the queue fills,
// then full rises. Reset restores the default timings, empties the queue and
// closes any open message. Timing registers are written through cfg_write,
// cfg_index and cfg_data; indexes beyond the last register are ignored.
// ----------------------------------------------------------------------------
module morse_code_keyer import mck_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [SYM_W-1:0]     symbol,
  output logic                 empty,
  input  logic                 pop,
  output logic                 light_on,
  output logic [TICK_W-1:0]    duration,
  output logic                 last,
  output logic                 idle,
  output logic                 bad_symbol,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_data
);

  cfg_t  cfg;
  logic  q_full;
  logic  q_push;
  desc_t q_data;
  logic  q_valid;
  logic  q_pop;
  desc_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dot        <= DOT_RESET;
      cfg.dash       <= DASH_RESET;
      cfg.elem_gap   <= ELEM_GAP_RESET;
      cfg.letter_gap <= LETTER_GAP_RESET;
      cfg.word_gap   <= WORD_GAP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DOT:        cfg.dot        <= cfg_data;
        REG_DASH:       cfg.dash       <= cfg_data;
        REG_ELEM_GAP:   cfg.elem_gap   <= cfg_data;
        REG_LETTER_GAP: cfg.letter_gap <= cfg_data;
        REG_WORD_GAP:   cfg.word_gap   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  mck_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .symbol (symbol),
    .full   (full),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_data)
  );

  mck_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .data_in (q_data),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .head    (q_head)
  );

  mck_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (q_head),
    .head_valid (q_valid),
    .head_pop   (q_pop),
    .pop        (pop),
    .empty      (empty),
    .light_on   (light_on),
    .duration   (duration),
    .last       (last),
    .idle       (idle),
    .bad_symbol (bad_symbol)
  );

endmodule
